@@ rtl/core/tle_pkg.sv @@
// Shared types, control word layout and character codes of the terminal line editor.
package tle_pkg;

  localparam int STEP_W = 4;
  localparam int LIM_W = 9;
  localparam int MAX_CHARS = 63;

  localparam logic [7:0] KEY_ETX = 8'h03;
  localparam logic [7:0] KEY_EOT = 8'h04;
  localparam logic [7:0] KEY_BS = 8'h08;
  localparam logic [7:0] KEY_DEL = 8'h7f;
  localparam logic [7:0] KEY_CR = 8'h0d;
  localparam logic [7:0] KEY_LF = 8'h0a;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_OK = 2'd1;
  localparam logic [1:0] KIND_OVF = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_TST_END = 4'd1;
  localparam logic [STEP_W-1:0] STEP_TST_ETX = 4'd2;
  localparam logic [STEP_W-1:0] STEP_TST_EOL = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TST_BS = 4'd4;
  localparam logic [STEP_W-1:0] STEP_PUT = 4'd5;
  localparam logic [STEP_W-1:0] STEP_BACK = 4'd6;
  localparam logic [STEP_W-1:0] STEP_END = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ETX = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EOL = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LOOP = 4'd10;
  localparam logic [STEP_W-1:0] STEP_CHAR = 4'd11;
  localparam logic [STEP_W-1:0] STEP_STATUS = 4'd12;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT,
    OP_BACK,
    OP_CLEAR,
    OP_RDSTART,
    OP_NEXT
  } dp_op_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CHAR,
    EM_STATUS,
    EM_OK,
    EM_END
  } emit_t;

  typedef enum logic [2:0] {
    CD_NONE,
    CD_ALWAYS,
    CD_NO_ACCEPT,
    CD_IS_END,
    CD_IS_ETX,
    CD_IS_EOL,
    CD_IS_BS,
    CD_LINE_DONE
  } cond_t;

  typedef struct packed {
    logic take;
    dp_op_t op;
    emit_t emit;
    cond_t cond;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic is_end;
    logic is_etx;
    logic is_eol;
    logic is_bs;
    logic line_done;
    logic slot_free;
  } dp_stat_t;

endpackage

@@ rtl/core/tle_seq.sv @@
// Microcode sequencer: step counter, control store and conditional jumps.
module tle_seq
  import tle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output ucw_t     ucw,
  output logic     go
);

  logic [STEP_W-1:0] upc_r;
  logic [STEP_W-1:0] upc_nxt;
  logic              cond_true;

  // Control store.
  always_comb begin
    ucw = '{take: 1'b0, op: OP_NONE, emit: EM_NONE, cond: CD_ALWAYS, target: STEP_WAIT};
    case (upc_r)
      STEP_WAIT: begin
        ucw = '{take: 1'b1, op: OP_NONE, emit: EM_NONE, cond: CD_NO_ACCEPT,
                target: STEP_WAIT};
      end
      STEP_TST_END: begin
        ucw = '{take: 1'b0, op: OP_NONE, emit: EM_NONE, cond: CD_IS_END, target: STEP_END};
      end
      STEP_TST_ETX: begin
        ucw = '{take: 1'b0, op: OP_NONE, emit: EM_NONE, cond: CD_IS_ETX, target: STEP_ETX};
      end
      STEP_TST_EOL: begin
        ucw = '{take: 1'b0, op: OP_NONE, emit: EM_NONE, cond: CD_IS_EOL, target: STEP_EOL};
      end
      STEP_TST_BS: begin
        ucw = '{take: 1'b0, op: OP_NONE, emit: EM_NONE, cond: CD_IS_BS, target: STEP_BACK};
      end
      STEP_PUT: begin
        ucw = '{take: 1'b0, op: OP_PUT, emit: EM_NONE, cond: CD_ALWAYS, target: STEP_WAIT};
      end
      STEP_BACK: begin
        ucw = '{take: 1'b0, op: OP_BACK, emit: EM_NONE, cond: CD_ALWAYS, target: STEP_WAIT};
      end
      STEP_END: begin
        ucw = '{take: 1'b0, op: OP_CLEAR, emit: EM_END, cond: CD_ALWAYS, target: STEP_WAIT};
      end
      STEP_ETX: begin
        ucw = '{take: 1'b0, op: OP_CLEAR, emit: EM_OK, cond: CD_ALWAYS, target: STEP_WAIT};
      end
      STEP_EOL: begin
        ucw = '{take: 1'b0, op: OP_RDSTART, emit: EM_NONE, cond: CD_NONE,
                target: STEP_WAIT};
      end
      STEP_LOOP: begin
        ucw = '{take: 1'b0, op: OP_NONE, emit: EM_NONE, cond: CD_LINE_DONE,
                target: STEP_STATUS};
      end
      STEP_CHAR: begin
        ucw = '{take: 1'b0, op: OP_NEXT, emit: EM_CHAR, cond: CD_ALWAYS, target: STEP_LOOP};
      end
      STEP_STATUS: begin
        ucw = '{take: 1'b0, op: OP_CLEAR, emit: EM_STATUS, cond: CD_ALWAYS,
                target: STEP_WAIT};
      end
      default: begin
        ucw = '{take: 1'b0, op: OP_NONE, emit: EM_NONE, cond: CD_ALWAYS, target: STEP_WAIT};
      end
    endcase
  end

  always_comb begin
    case (ucw.cond)
      CD_NONE:      cond_true = 1'b0;
      CD_ALWAYS:    cond_true = 1'b1;
      CD_NO_ACCEPT: cond_true = !in_valid;
      CD_IS_END:    cond_true = stat.is_end;
      CD_IS_ETX:    cond_true = stat.is_etx;
      CD_IS_EOL:    cond_true = stat.is_eol;
      CD_IS_BS:     cond_true = stat.is_bs;
      CD_LINE_DONE: cond_true = stat.line_done;
      default:      cond_true = 1'b0;
    endcase
  end

  // A step that emits waits in place until the output register has room.
  always_comb begin
    go = (ucw.emit == EM_NONE) || stat.slot_free;
    if (!go) begin
      upc_nxt = upc_r;
    end else if (cond_true) begin
      upc_nxt = ucw.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

@@ rtl/core/tle_datapath.sv @@
// Datapath: line store, write position, overflow flag and result register.
module tle_datapath
  import tle_pkg::*;
#(
  parameter int LINE_CAPACITY = 64
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  ucw_t       ucw,
  input  logic       go,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       end_of_input,
  input  logic [6:0] line_limit,
  input  logic       out_stall,
  output dp_stat_t   stat,
  output logic       out_valid,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_line_char,
  output logic [5:0] out_line_length,
  output logic       out_last_in_run
);

  localparam int PW = $clog2(LINE_CAPACITY);

  logic [7:0]       char_r;
  logic             eoi_r;
  logic [PW-1:0]    pos_r;
  logic [PW-1:0]    pos_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic [PW-1:0]    idx_r;
  logic [7:0]       rdata_r;
  logic [7:0]       mem [LINE_CAPACITY];
  logic [LIM_W-1:0] lim_eff;
  logic [LIM_W-1:0] pos_ext;
  logic [LIM_W-1:0] pos_dec;
  logic             put_ok;
  logic             out_valid_r;
  logic [1:0]       kind_r;
  logic [7:0]       lchar_r;
  logic [5:0]       len_r;
  logic             last_r;

  always_comb begin
    if (line_limit == 7'd0) begin
      lim_eff = LIM_W'(1);
    end else if (LIM_W'(line_limit) > LIM_W'(LINE_CAPACITY)) begin
      lim_eff = LIM_W'(LINE_CAPACITY);
    end else begin
      lim_eff = LIM_W'(line_limit);
    end
  end

  assign pos_ext = LIM_W'(pos_r);
  assign pos_dec = pos_ext - LIM_W'(1);
  assign put_ok = pos_ext < (lim_eff - LIM_W'(1));

  assign stat.is_end = eoi_r || (char_r == KEY_EOT);
  assign stat.is_etx = char_r == KEY_ETX;
  assign stat.is_eol = (char_r == KEY_CR) || (char_r == KEY_LF);
  assign stat.is_bs = (char_r == KEY_BS) || (char_r == KEY_DEL);
  assign stat.line_done = !((LIM_W'(idx_r) < pos_ext) &&
                            (LIM_W'(idx_r) < LIM_W'(MAX_CHARS)));
  assign stat.slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= char_in;
      eoi_r <= end_of_input;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    if (go) begin
      case (ucw.op)
        OP_PUT: begin
          if (put_ok) begin
            pos_nxt = pos_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_BACK: begin
          if (pos_r != '0) begin
            pos_nxt = pos_r - 1'b1;
            if (pos_dec < lim_eff) begin
              ovf_nxt = 1'b0;
            end
          end
        end
        OP_CLEAR: begin
          pos_nxt = '0;
          ovf_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // The read port samples the readout index every cycle into the read data register.
  always_ff @(posedge clk) begin
    if (go && (ucw.op == OP_PUT) && put_ok) begin
      mem[pos_r] <= char_r;
    end
    rdata_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (go && (ucw.op == OP_RDSTART)) begin
      idx_r <= '0;
    end else if (go && (ucw.op == OP_NEXT)) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && (ucw.emit != EM_NONE)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (ucw.emit != EM_NONE)) begin
      case (ucw.emit)
        EM_CHAR: begin
          kind_r <= KIND_CHAR;
          lchar_r <= rdata_r;
          len_r <= 6'd0;
          last_r <= 1'b0;
        end
        EM_STATUS: begin
          kind_r <= ovf_r ? KIND_OVF : KIND_OK;
          lchar_r <= 8'd0;
          len_r <= pos_ext[5:0];
          last_r <= 1'b1;
        end
        EM_END: begin
          kind_r <= KIND_END;
          lchar_r <= 8'd0;
          len_r <= 6'd0;
          last_r <= 1'b1;
        end
        default: begin
          kind_r <= KIND_OK;
          lchar_r <= 8'd0;
          len_r <= 6'd0;
          last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_line_char = lchar_r;
  assign out_line_length = len_r;
  assign out_last_in_run = last_r;

endmodule

@@ rtl/core/terminal_line_editor.sv @@
// Terminal line editor, top level: configuration register, sequencer and datapath.
//
// Characters enter one transaction at a time and are run through a short
// microprogram of test steps for end, Ctrl-C, line end and backspace,
// followed by a put or back step for a plain character or a backspace.
// Ctrl-C, Ctrl-D and end of input each end in a step whose result may wait
// for room in the output register. A line end reads the stored line back
// through the single registered read port of the line store, at most 63
// emitted characters and then a status result. One output register parts the
// sides: a result stays there while out_stall is high and the sequencer moves
// on until its next result. line_limit is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; the block does not
// enforce this. 0 acts as 1 and values above LINE_CAPACITY act as LINE_CAPACITY.
module terminal_line_editor
  import tle_pkg::*;
#(
  parameter int LINE_CAPACITY = 64
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_line_char,
  output logic [5:0] out_line_length,
  output logic       out_last_in_run
);

  logic [6:0] line_limit_r;
  ucw_t       ucw;
  logic       go;
  dp_stat_t   stat;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= 7'd64;
    end else if (cfg_wr_en) begin
      line_limit_r <= cfg_wr_data;
    end
  end

  assign in_stall = !ucw.take;
  assign accept = in_valid && ucw.take;

  tle_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ucw      (ucw),
    .go       (go)
  );

  tle_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ucw             (ucw),
    .go              (go),
    .accept          (accept),
    .char_in         (in_char_in),
    .end_of_input    (in_end_of_input),
    .line_limit      (line_limit_r),
    .out_stall       (out_stall),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_line_char   (out_line_char),
    .out_line_length (out_line_length),
    .out_last_in_run (out_last_in_run)
  );

  // Only one transaction is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while the previous one is in work");

  a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_CHAR)) |-> !out_last_in_run)
    else $error("line character marked as last result");

  a_status_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind != KIND_CHAR)) |-> (out_line_char == 8'd0))
    else $error("status result carries a character");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind != KIND_CHAR)) |-> out_last_in_run)
    else $error("status result not marked as last");

endmodule

@@ dv/terminal_line_editor_test.sv @@
// Self-checking testbench of the terminal line editor: directed script, then random lines.
module terminal_line_editor_test;
  import tle_pkg::*;

  localparam int LINE_CAPACITY = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [5:0] len;
    logic       last;
  } line_result_t;

  typedef struct packed {
    logic       is_cfg;
    logic [6:0] cfg;
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
    logic [1:0] kind;
    logic [5:0] len;
  } script_row_t;

  typedef struct packed {
    logic [6:0] limit;
    logic [7:0] send_idle;
    logic [7:0] stall;
    logic       hold;
    logic [7:0] long_len;
  } phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = 7'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'd0;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [7:0] out_line_char;
  logic [5:0] out_line_length;
  logic       out_last_in_run;

  // Own copy of the editor state.
  logic [7:0] line_store_m [LINE_CAPACITY];
  int         write_pos_m = 0;
  bit         overflow_m = 1'b0;
  logic [6:0] line_limit_m = 7'd64;

  line_result_t step_results [$];
  line_result_t pending_results [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Rows with a typed-in result expect exactly one status item.
  script_row_t script [30] = '{
    '{1'b0, 7'd0, 8'hff,   1'b1, 1'b1, KIND_END,  6'd0},
    '{1'b0, 7'd0, KEY_ETX, 1'b0, 1'b1, KIND_OK,   6'd0},
    '{1'b0, 7'd0, KEY_CR,  1'b0, 1'b1, KIND_OK,   6'd0},
    '{1'b0, 7'd0, KEY_BS,  1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h41,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h00,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'hff,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, KEY_DEL, 1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, KEY_CR,  1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, KEY_LF,  1'b0, 1'b1, KIND_OK,   6'd0},
    '{1'b0, 7'd0, KEY_EOT, 1'b0, 1'b1, KIND_END,  6'd0},
    '{1'b1, 7'd3, 8'h00,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h61,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h62,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h63,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, KEY_LF,  1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b1, 7'd64, 8'h00,  1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h31,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h32,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h33,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h34,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h35,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b1, 7'd2, 8'h00,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h7a,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, KEY_BS,  1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, KEY_CR,  1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b1, 7'd0, 8'h00,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, 8'h6b,   1'b0, 1'b0, KIND_CHAR, 6'd0},
    '{1'b0, 7'd0, KEY_CR,  1'b0, 1'b1, KIND_OVF,  6'd0},
    '{1'b1, 7'd127, 8'h00, 1'b0, 1'b0, KIND_CHAR, 6'd0}
  };

  phase_t phases [6] = '{
    '{7'd64,  8'd0,  8'd0,  1'b0, 8'd0},
    '{7'd5,   8'd78, 8'd0,  1'b0, 8'd0},
    '{7'd127, 8'd0,  8'd78, 1'b0, 8'd66},
    '{7'd1,   8'd16, 8'd16, 1'b0, 8'd0},
    '{7'd20,  8'd0,  8'd0,  1'b1, 8'd0},
    '{7'd64,  8'd16, 8'd16, 1'b0, 8'd0}
  };

  terminal_line_editor #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_in(in_char_in),
    .in_end_of_input(in_end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_kind(out_result_kind),
    .out_line_char(out_line_char),
    .out_line_length(out_line_length),
    .out_last_in_run(out_last_in_run)
  );

  always #10 clk = ~clk;

  function automatic void predict_edit(input logic [7:0] ch, input logic eoi);
    int lim;
    int n_chars;
    line_result_t r;
    lim = (line_limit_m == 7'd0) ? 1 :
          ((int'(line_limit_m) > LINE_CAPACITY) ? LINE_CAPACITY : int'(line_limit_m));
    step_results.delete();
    if (eoi || ch == KEY_EOT) begin
      step_results.push_back('{KIND_END, 8'd0, 6'd0, 1'b0});
      write_pos_m = 0;
      overflow_m = 1'b0;
    end else if (ch == KEY_ETX) begin
      step_results.push_back('{KIND_OK, 8'd0, 6'd0, 1'b0});
      write_pos_m = 0;
      overflow_m = 1'b0;
    end else if (ch == KEY_CR || ch == KEY_LF) begin
      n_chars = (write_pos_m < MAX_CHARS) ? write_pos_m : MAX_CHARS;
      for (int i = 0; i < n_chars; i++) begin
        step_results.push_back('{KIND_CHAR, line_store_m[i], 6'd0, 1'b0});
      end
      step_results.push_back('{overflow_m ? KIND_OVF : KIND_OK, 8'd0, 6'(write_pos_m), 1'b0});
      write_pos_m = 0;
      overflow_m = 1'b0;
    end else if (ch == KEY_BS || ch == KEY_DEL) begin
      if (write_pos_m > 0) begin
        write_pos_m--;
        // With a lowered limit the flag survives until the line fits again.
        if (write_pos_m < lim) overflow_m = 1'b0;
      end
    end else if (write_pos_m < lim - 1 && write_pos_m < LINE_CAPACITY) begin
      line_store_m[write_pos_m] = ch;
      write_pos_m++;
    end else begin
      overflow_m = 1'b1;
    end
    if (step_results.size() > 0) begin
      r = step_results[step_results.size() - 1];
      r.last = 1'b1;
      step_results[step_results.size() - 1] = r;
    end
  endfunction

  task automatic offer_char(input logic [7:0] ch, input logic eoi, input bit typed,
                            input line_result_t typed_res);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= ch;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_edit(ch, eoi);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // Drain all results and let a result-free transaction finish inside the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    line_limit_m = value;
  endtask

  task automatic send_line(input int len, input bit edits, output int items);
    int pick;
    items = len + 1;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (edits && pick < 12) begin
        offer_char(pick[0] ? KEY_BS : KEY_DEL, 1'b0, 1'b0, '0);
      end else if (edits && pick < 17) begin
        offer_char(8'($urandom_range(255)), 1'b0, 1'b0, '0);
      end else if (pick < 27) begin
        offer_char(8'($urandom_range(255, 128)), 1'b0, 1'b0, '0);
      end else begin
        offer_char(8'($urandom_range(126, 32)), 1'b0, 1'b0, '0);
      end
    end
    if (!edits) begin
      offer_char(KEY_CR, 1'b0, 1'b0, '0);
    end else begin
      case ($urandom_range(9))
        0, 1, 2: offer_char(KEY_CR, 1'b0, 1'b0, '0);
        3, 4, 5: offer_char(KEY_LF, 1'b0, 1'b0, '0);
        6: offer_char(KEY_ETX, 1'b0, 1'b0, '0);
        7: offer_char(KEY_EOT, 1'b0, 1'b0, '0);
        8: offer_char(8'($urandom_range(255)), 1'b1, 1'b0, '0);
        default: begin
          offer_char(KEY_CR, 1'b0, 1'b0, '0);
          offer_char(KEY_LF, 1'b0, 1'b0, '0);
          items++;
        end
      endcase
    end
  endtask

  // Receiver: random stalls, or a long hold-off that backs the block up.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    line_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: kind %0d char %0h length %0d",
               out_result_kind, out_line_char, out_line_length);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_result_kind);
          error_count++;
        end
        if (out_line_char !== want.ch) begin
          $error("line_char: expected %0h, got %0h", want.ch, out_line_char);
          error_count++;
        end
        if (out_line_length !== want.len) begin
          $error("line_length: expected %0d, got %0d", want.len, out_line_length);
          error_count++;
        end
        if (out_last_in_run !== want.last) begin
          $error("last_in_run: expected %0d, got %0d", want.last, out_last_in_run);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int sent;
    int items;
    int len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_limit(script[i].cfg);
      end else begin
        offer_char(script[i].ch, script[i].eoi, script[i].typed,
                   '{script[i].kind, 8'd0, script[i].len, 1'b1});
      end
    end

    foreach (phases[p]) begin
      write_limit(phases[p].limit);
      send_idle = phases[p].send_idle;
      stall_pct <= phases[p].stall;
      if (phases[p].hold) hold_token <= hold_token + 1;
      if (phases[p].long_len != 0) send_line(phases[p].long_len, 1'b0, items);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(5) == 0) ? $urandom_range(24) : $urandom_range(8);
        send_line(len, 1'b1, items);
        sent += items;
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
